// File: rtl/strided_conv2d_valid_unit_defines.svh
// ----------------------------------------------------------------------------
// Strided conv2d unit assertion macros
// Shared property wrappers clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef STRIDED_CONV2D_VALID_UNIT_DEFINES_SVH
`define STRIDED_CONV2D_VALID_UNIT_DEFINES_SVH

// Same-cycle implication.
`define SCV_ASSERT_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scv: same-cycle check failed");

// Next-cycle implication.
`define SCV_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scv: next-cycle check failed");

`endif

// File: rtl/scv_pkg.sv
// ----------------------------------------------------------------------------
// scv_pkg
// Request/result types, field widths and register indexes of the conv2d unit.
// ----------------------------------------------------------------------------
package scv_pkg;

  localparam int VALUE_BITS     = 16;
  localparam int CONV_BITS      = 40;
  localparam int ROW_BITS       = 12;
  localparam int COL_BITS       = 10;
  localparam int IMG_ROW_BITS   = 13;
  localparam int STEP_BITS      = 4;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 13;
  localparam int MAX_ROWS       = 4096;
  localparam int MAX_STEP       = 8;
  localparam int PHASE_BITS     = 3;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_ROWS  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_COLS  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_KERNEL_ROWS = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_KERNEL_COLS = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_STEP_SIZE   = 3'd4;

  // request modes
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_WEIGHT = 1'b1;

  typedef struct packed {
    logic                         mode;
    logic signed [VALUE_BITS-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [CONV_BITS-1:0] conv_value;
    logic [ROW_BITS-1:0]         out_row;
    logic [COL_BITS-1:0]         out_col;
    logic                        last_of_frame;
  } out_item_t;

endpackage

// File: rtl/scv_ram.sv
// ----------------------------------------------------------------------------
// scv_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module scv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/scv_div.sv
// ----------------------------------------------------------------------------
// scv_div
// Restoring divider, one quotient bit per cycle, by a small stride divisor.
// ----------------------------------------------------------------------------
module scv_div #(
  parameter int DW = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [DW-1:0]                 dividend,
  input  logic [scv_pkg::STEP_BITS-1:0] divisor,
  output logic [DW-1:0]                 quot,
  output logic [scv_pkg::STEP_BITS-1:0] rem,
  output logic                          done
);
  import scv_pkg::*;

  localparam int CNTW = $clog2(DW + 1);

  logic [DW-1:0]        shift_r;
  logic [STEP_BITS-1:0] rem_r;
  logic [STEP_BITS-1:0] div_r;
  logic [CNTW-1:0]      cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [STEP_BITS:0]   trial;
  logic                 ge;

  assign trial = {rem_r, shift_r[DW-1]};
  assign ge    = (trial >= {1'b0, div_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNTW'(DW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNTW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
    if (start) begin
      shift_r <= dividend;
      rem_r   <= '0;
      div_r   <= divisor;
    end else if (busy_r) begin
      shift_r <= {shift_r[DW-2:0], ge};
      rem_r   <= ge ? STEP_BITS'(trial - {1'b0, div_r}) : STEP_BITS'(trial);
    end
  end

  assign quot = shift_r;
  assign rem  = rem_r;
  assign done = done_r;

endmodule

// File: rtl/scv_mac.sv
// ----------------------------------------------------------------------------
// scv_mac
// Shared multiply-accumulate: registered product, then 40-bit wrap-around sum.
// ----------------------------------------------------------------------------
module scv_mac #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          clear,
  input  logic                          tap_valid,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic signed [SAMPLE_BITS-1:0] weight,
  output logic [scv_pkg::CONV_BITS-1:0] acc,
  output logic                          busy
);
  import scv_pkg::*;

  logic signed [2*SAMPLE_BITS-1:0] prod_r;
  logic                            pv_r;
  logic [CONV_BITS-1:0]            acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= tap_valid;
    end
    prod_r <= sample * weight;
    if (clear) begin
      acc_r <= '0;
    end else if (pv_r) begin
      acc_r <= acc_r + CONV_BITS'(prod_r);
    end
  end

  assign acc  = acc_r;
  assign busy = pv_r;

endmodule

// File: rtl/strided_conv2d_valid_unit.sv
// ----------------------------------------------------------------------------
// strided_conv2d_valid_unit
// Streaming valid 2D correlation with stride over a MAX_KERNEL-row line store.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake             Payload
//  in_      in   in_valid / in_stall   scv_pkg::in_item_t (mode, value)
//  out_     out  out_valid / out_stall scv_pkg::out_item_t (sum, row, col, last)
//  cfg_     in   cfg_valid / cfg_ready cfg_index, cfg_data (ready tied high)
//
//  Weight requests and samples that close no grid window leave in_stall low.
//  A sample that closes a window holds in_stall until the window is done:
//  one kernel tap per cycle through the single multiply-accumulate, or the
//  quotient units for row/column indexes when the kernel is small.
//  rst_n (sync) clears counters, phases and sets every register to 1; the line
//  and kernel stores are not cleared. A stalled result holds in the output
//  register; the next request is still taken, but a new window completes only
//  once that register is free.
// ----------------------------------------------------------------------------
`include "strided_conv2d_valid_unit_defines.svh"

module strided_conv2d_valid_unit #(
  parameter int MAX_COLS    = 1024,
  parameter int MAX_KERNEL  = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  scv_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output scv_pkg::out_item_t                 out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [scv_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [scv_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import scv_pkg::*;

  localparam int CW     = $clog2(MAX_COLS);              // column counter
  localparam int CNW    = $clog2(MAX_COLS + 1);          // column count
  localparam int KW     = $clog2(MAX_KERNEL + 1);        // kernel dimension
  localparam int SW     = $clog2(MAX_KERNEL);            // line slot
  localparam int TSW    = SW + 2;
  localparam int LDEPTH = MAX_KERNEL * MAX_COLS;
  localparam int LAW    = $clog2(LDEPTH);
  localparam int KDEPTH = MAX_KERNEL * MAX_KERNEL;
  localparam int KAW    = $clog2(KDEPTH);
  localparam int KSW    = $clog2(KDEPTH + 1);
  localparam int CMPW   = 14;                            // common compare width
  localparam int XW     = VALUE_BITS + SAMPLE_BITS;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN} state_t;

  // configuration (stored already clamped)
  logic [IMG_ROW_BITS-1:0] rows_r, rows_nxt;
  logic [CNW-1:0]          cols_r, cols_nxt;
  logic [KW-1:0]           kr_r, kr_nxt, kc_r, kc_nxt;
  logic [STEP_BITS-1:0]    step_r, step_nxt;

  // stream position
  logic [ROW_BITS-1:0]   pixel_row_r, pixel_row_nxt;
  logic [CW-1:0]         pixel_col_r, pixel_col_nxt;
  logic [SW-1:0]         row_slot_r, row_slot_nxt;
  logic [PHASE_BITS-1:0] row_phase_r, row_phase_nxt;
  logic [PHASE_BITS-1:0] col_phase_r, col_phase_nxt;
  logic [KAW-1:0]        kptr_r, kptr_nxt;

  // window sequencer
  state_t         state_r, state_nxt;
  logic [KAW-1:0] tap_idx_r, tap_idx_nxt;
  logic [KW-1:0]  tap_col_r, tap_col_nxt;
  logic [SW-1:0]  tap_slot_r, tap_slot_nxt;
  logic [CW-1:0]  left_r, left_nxt;
  logic           rd_valid_r, rd_valid_nxt;
  logic           last_row_r, last_row_nxt;
  logic           last_col_r, last_col_nxt;
  logic           out_valid_r, out_valid_nxt;
  out_item_t      out_data_r, out_data_nxt;

  // combinational
  logic                   accept, cfg_we, win_emit, out_free;
  logic [ROW_BITS-1:0]    r_eff, top_row;
  logic [CW-1:0]          c_eff, left_col;
  logic [SW-1:0]          slot_eff, top_slot;
  logic [TSW-1:0]         tsum;
  logic [PHASE_BITS-1:0]  rph_eff, cph_eff;
  logic                   row_full, col_full;
  logic [KSW-1:0]         ksize;
  logic [KAW-1:0]         kp_eff;
  logic [XW-1:0]          vwide;
  logic [SAMPLE_BITS-1:0] samp;
  logic                   lram_we, kram_we;
  logic [LAW-1:0]         lram_waddr, lram_raddr;
  logic [SAMPLE_BITS-1:0] lram_rdata, kram_rdata;
  logic [CONV_BITS-1:0]   mac_acc;
  logic                   mac_busy, mac_clear;
  logic [ROW_BITS-1:0]    row_quot;
  logic [CW-1:0]          col_quot;
  logic [STEP_BITS-1:0]   row_rem, col_rem;
  logic                   row_done, col_done;

  function automatic logic [PHASE_BITS-1:0] next_phase(input logic [PHASE_BITS-1:0] ph,
                                                       input logic [STEP_BITS-1:0] step);
    logic [STEP_BITS-1:0] inc;
    inc = STEP_BITS'(ph) + 1'b1;
    return (inc >= step) ? '0 : PHASE_BITS'(inc);
  endfunction

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    logic [SW:0] inc;
    inc = (SW + 1)'(s) + 1'b1;
    return (inc == (SW + 1)'(MAX_KERNEL)) ? '0 : SW'(inc);
  endfunction

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;
  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid & ~in_stall;
  assign out_free  = ~out_valid_r | ~out_stall;

  // only the low SAMPLE_BITS of the value count, as two's complement
  assign vwide = {{SAMPLE_BITS{1'b0}}, in_data.value};
  assign samp  = vwide[SAMPLE_BITS-1:0];

  // position after restarting out-of-range counters (size change mid-frame)
  always_comb begin
    c_eff    = pixel_col_r;
    cph_eff  = col_phase_r;
    r_eff    = pixel_row_r;
    rph_eff  = row_phase_r;
    slot_eff = row_slot_r;
    if (CMPW'(pixel_col_r) >= CMPW'(cols_r)) begin
      c_eff   = '0;
      cph_eff = '0;
    end
    if (CMPW'(pixel_row_r) >= CMPW'(rows_r)) begin
      r_eff    = '0;
      rph_eff  = '0;
      slot_eff = '0;
    end
  end

  assign row_full = (CMPW'(r_eff) + 1'b1 >= CMPW'(kr_r));
  assign col_full = (CMPW'(c_eff) + 1'b1 >= CMPW'(kc_r));
  assign win_emit = (in_data.mode == MODE_SAMPLE) && row_full && col_full &&
                    (rph_eff == '0) && (cph_eff == '0);

  assign top_row  = ROW_BITS'(CMPW'(r_eff) + 1'b1 - CMPW'(kr_r));
  assign left_col = CW'(CMPW'(c_eff) + 1'b1 - CMPW'(kc_r));

  // line slot of the window's top row: (slot - (kr - 1)) mod MAX_KERNEL
  assign tsum     = TSW'(slot_eff) + TSW'(MAX_KERNEL) + 1'b1 - TSW'(kr_r);
  assign top_slot = (tsum >= TSW'(MAX_KERNEL)) ? SW'(tsum - TSW'(MAX_KERNEL)) : SW'(tsum);

  // kernel size and write pointer
  assign ksize  = KSW'(kr_r) * KSW'(kc_r);
  assign kp_eff = (KSW'(kptr_r) >= ksize) ? '0 : kptr_r;

  assign lram_we    = accept && (in_data.mode == MODE_SAMPLE);
  assign kram_we    = accept && (in_data.mode == MODE_WEIGHT);
  assign lram_waddr = LAW'(slot_eff) * LAW'(MAX_COLS) + LAW'(c_eff);
  assign lram_raddr = LAW'(tap_slot_r) * LAW'(MAX_COLS) + LAW'(left_r) + LAW'(tap_col_r);
  assign mac_clear  = accept && win_emit;

  scv_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(LDEPTH)) u_line_ram (
    .clk   (clk),
    .we    (lram_we),
    .waddr (lram_waddr),
    .wdata (samp),
    .raddr (lram_raddr),
    .rdata (lram_rdata)
  );

  scv_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(KDEPTH)) u_kern_ram (
    .clk   (clk),
    .we    (kram_we),
    .waddr (kp_eff),
    .wdata (samp),
    .raddr (tap_idx_r),
    .rdata (kram_rdata)
  );

  scv_mac #(.SAMPLE_BITS(SAMPLE_BITS)) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (mac_clear),
    .tap_valid (rd_valid_r),
    .sample    (lram_rdata),
    .weight    (kram_rdata),
    .acc       (mac_acc),
    .busy      (mac_busy)
  );

  // output row/column = window corner divided by the stride
  scv_div #(.DW(ROW_BITS)) u_row_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mac_clear),
    .dividend (top_row),
    .divisor  (step_r),
    .quot     (row_quot),
    .rem      (row_rem),
    .done     (row_done)
  );

  scv_div #(.DW(CW)) u_col_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mac_clear),
    .dividend (left_col),
    .divisor  (step_r),
    .quot     (col_quot),
    .rem      (col_rem),
    .done     (col_done)
  );

  always_comb begin
    rows_nxt      = rows_r;
    cols_nxt      = cols_r;
    kr_nxt        = kr_r;
    kc_nxt        = kc_r;
    step_nxt      = step_r;
    pixel_row_nxt = pixel_row_r;
    pixel_col_nxt = pixel_col_r;
    row_slot_nxt  = row_slot_r;
    row_phase_nxt = row_phase_r;
    col_phase_nxt = col_phase_r;
    kptr_nxt      = kptr_r;
    state_nxt     = state_r;
    tap_idx_nxt   = tap_idx_r;
    tap_col_nxt   = tap_col_r;
    tap_slot_nxt  = tap_slot_r;
    left_nxt      = left_r;
    rd_valid_nxt  = 1'b0;
    last_row_nxt  = last_row_r;
    last_col_nxt  = last_col_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    // register writes, clamped into range; zero counts as one
    if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_ROWS: begin
          if (cfg_data == '0) rows_nxt = IMG_ROW_BITS'(1);
          else if (int'(cfg_data) > MAX_ROWS) rows_nxt = IMG_ROW_BITS'(MAX_ROWS);
          else rows_nxt = cfg_data;
        end
        CFG_IMAGE_COLS: begin
          if (cfg_data[10:0] == '0) cols_nxt = CNW'(1);
          else if (int'(cfg_data[10:0]) > MAX_COLS) cols_nxt = CNW'(MAX_COLS);
          else cols_nxt = CNW'(cfg_data[10:0]);
        end
        CFG_KERNEL_ROWS: begin
          if (cfg_data[3:0] == '0) kr_nxt = KW'(1);
          else if (int'(cfg_data[3:0]) > MAX_KERNEL) kr_nxt = KW'(MAX_KERNEL);
          else kr_nxt = KW'(cfg_data[3:0]);
        end
        CFG_KERNEL_COLS: begin
          if (cfg_data[3:0] == '0) kc_nxt = KW'(1);
          else if (int'(cfg_data[3:0]) > MAX_KERNEL) kc_nxt = KW'(MAX_KERNEL);
          else kc_nxt = KW'(cfg_data[3:0]);
        end
        CFG_STEP_SIZE: begin
          if (cfg_data[3:0] == '0) step_nxt = STEP_BITS'(1);
          else if (int'(cfg_data[3:0]) > MAX_STEP) step_nxt = STEP_BITS'(MAX_STEP);
          else step_nxt = cfg_data[3:0];
        end
        default: ;
      endcase
    end

    // result register drains independently of the sequencer
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // weight: row-major store, pointer wraps at kernel size
    if (kram_we) begin
      kptr_nxt = (KSW'(kp_eff) + 1'b1 >= ksize) ? '0 : KAW'(KSW'(kp_eff) + 1'b1);
    end

    // sample: advance position and stride phases
    if (lram_we) begin
      pixel_row_nxt = r_eff;
      pixel_col_nxt = c_eff;
      row_slot_nxt  = slot_eff;
      row_phase_nxt = rph_eff;
      col_phase_nxt = cph_eff;
      if (row_full && col_full) begin
        col_phase_nxt = next_phase(cph_eff, step_r);
      end
      if (CMPW'(c_eff) + 1'b1 >= CMPW'(cols_r)) begin
        if (row_full) begin
          row_phase_nxt = next_phase(rph_eff, step_r);
        end
        pixel_col_nxt = '0;
        col_phase_nxt = '0;
        if (CMPW'(r_eff) + 1'b1 >= CMPW'(rows_r)) begin
          pixel_row_nxt = '0;
          row_phase_nxt = '0;
          row_slot_nxt  = '0;
        end else begin
          pixel_row_nxt = r_eff + 1'b1;
          row_slot_nxt  = slot_inc(slot_eff);
        end
      end else begin
        pixel_col_nxt = c_eff + 1'b1;
      end

      if (win_emit) begin
        state_nxt    = S_RUN;
        tap_idx_nxt  = '0;
        tap_col_nxt  = '0;
        tap_slot_nxt = top_slot;
        left_nxt     = left_col;
        // last window iff within one stride of the far edges and on the grid
        last_row_nxt = (CMPW'(rows_r) - CMPW'(r_eff) - 1'b1 < CMPW'(step_r));
        last_col_nxt = (CMPW'(cols_r) - CMPW'(c_eff) - 1'b1 < CMPW'(step_r));
      end
    end

    case (state_r)
      S_IDLE: ;
      S_RUN: begin
        // one tap per cycle, row-major across the window
        rd_valid_nxt = 1'b1;
        if (KSW'(tap_idx_r) + 1'b1 == ksize) begin
          state_nxt = S_DRAIN;
        end else begin
          tap_idx_nxt = tap_idx_r + 1'b1;
          if (KW'(tap_col_r + 1'b1) == kc_r) begin
            tap_col_nxt  = '0;
            tap_slot_nxt = slot_inc(tap_slot_r);
          end else begin
            tap_col_nxt = tap_col_r + 1'b1;
          end
        end
      end
      S_DRAIN: begin
        if (!rd_valid_r && !mac_busy && row_done && col_done && out_free) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.conv_value      = signed'(mac_acc);
          out_data_nxt.out_row         = row_quot;
          out_data_nxt.out_col         = COL_BITS'(col_quot);
          out_data_nxt.last_of_frame   = last_row_r && last_col_r &&
                                         (row_rem == '0) && (col_rem == '0);
          state_nxt                    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r      <= IMG_ROW_BITS'(1);
      cols_r      <= CNW'(1);
      kr_r        <= KW'(1);
      kc_r        <= KW'(1);
      step_r      <= STEP_BITS'(1);
      pixel_row_r <= '0;
      pixel_col_r <= '0;
      row_slot_r  <= '0;
      row_phase_r <= '0;
      col_phase_r <= '0;
      kptr_r      <= '0;
      state_r     <= S_IDLE;
      tap_idx_r   <= '0;
      tap_col_r   <= '0;
      tap_slot_r  <= '0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rows_r      <= rows_nxt;
      cols_r      <= cols_nxt;
      kr_r        <= kr_nxt;
      kc_r        <= kc_nxt;
      step_r      <= step_nxt;
      pixel_row_r <= pixel_row_nxt;
      pixel_col_r <= pixel_col_nxt;
      row_slot_r  <= row_slot_nxt;
      row_phase_r <= row_phase_nxt;
      col_phase_r <= col_phase_nxt;
      kptr_r      <= kptr_nxt;
      state_r     <= state_nxt;
      tap_idx_r   <= tap_idx_nxt;
      tap_col_r   <= tap_col_nxt;
      tap_slot_r  <= tap_slot_nxt;
      rd_valid_r  <= rd_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    // window payload, no reset needed
    left_r     <= left_nxt;
    last_row_r <= last_row_nxt;
    last_col_r <= last_col_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // no tap may still be in flight once the sequencer is back to idle
  `SCV_ASSERT_IMPLY(a_idle_no_taps, state_r == S_IDLE, !rd_valid_r && !mac_busy)
  // a completed window launches both index dividers
  `SCV_ASSERT_NEXT(a_window_starts_div, in_valid && !in_stall && win_emit, !row_done && !col_done)
  // tap counter never walks past the kernel
  `SCV_ASSERT_IMPLY(a_tap_in_kernel, state_r == S_RUN, KSW'(tap_idx_r) < ksize)

endmodule

// File: sim/strided_conv2d_valid_unit_tb.sv
// ----------------------------------------------------------------------------
// strided_conv2d_valid_unit_tb
// Self-checking bench for the strided valid 2D correlation unit. A clocked
// driver feeds weight and sample requests from a queue, a clocked monitor
// predicts every window sum, row, column and frame mark on acceptance and
// checks results in order. Directed frames hit the register limits, value
// extremes and size/stride changes in mid-frame; random frames follow.
// ----------------------------------------------------------------------------
module strided_conv2d_valid_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import scv_pkg::*;

  localparam int LINE_COLS      = 1024;
  localparam int KMAX           = 8;
  localparam int RANDOM_REQS    = 380;
  // Partial row / column runs under the clamped image sizes.
  localparam int COL_CLAMP_LEN  = 40;
  localparam int ROW_CLAMP_LEN  = 60;
  // Cycles that the unit may still spend on a window once the queue is empty:
  // enough for an 8x8 window, with margin.
  localparam int SETTLE_CYCLES  = 100;
  // Long receiver hold-off, started once during the row clamp frame.
  localparam int LONG_HOLD      = 400;
  // Slowest quiet stretch in a correct run is the long hold or a settle
  // pause, or a window plus both-side gaps. Ten times over.
  localparam int WATCHDOG_LIMIT = 4000;

  localparam logic signed [VALUE_BITS-1:0] VAL_MIN = 16'sh8000;
  localparam logic signed [VALUE_BITS-1:0] VAL_MAX = 16'sh7FFF;

  logic                      clk;
  logic                      rst_n     = 1'b0;
  logic                      in_valid  = 1'b0;
  logic                      in_stall;
  in_item_t                  in_data   = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  out_item_t                 out_data;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

  strided_conv2d_valid_unit #(
    .MAX_COLS   (LINE_COLS),
    .MAX_KERNEL (KMAX),
    .SAMPLE_BITS(VALUE_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Shadow of the unit: raw register values, stores, scan position, phases.
  // Starts in the post-reset state; reset is applied only once.
  // --------------------------------------------------------------------------
  logic [IMG_ROW_BITS-1:0]        reg_rows  = 13'd1;
  logic [10:0]                    reg_cols  = 11'd1;
  logic [3:0]                     reg_krows = 4'd1;
  logic [3:0]                     reg_kcols = 4'd1;
  logic [STEP_BITS-1:0]           reg_step  = 4'd1;
  logic signed [VALUE_BITS-1:0]   pix_mem [0:KMAX*LINE_COLS-1];
  logic signed [VALUE_BITS-1:0]   tap_mem [0:KMAX*KMAX-1];
  logic [ROW_BITS-1:0]            cur_row   = '0;
  logic [COL_BITS-1:0]            cur_col   = '0;
  logic [5:0]                     tap_ptr   = '0;
  logic [PHASE_BITS-1:0]          row_ph    = '0;
  logic [PHASE_BITS-1:0]          col_ph    = '0;

  out_item_t conv_expect_q[$];   // predicted windows, oldest first
  in_item_t  req_q[$];           // requests waiting for the driver

  int  mismatch_count = 0;
  int  out_count      = 0;
  int  idle_cycles    = 0;
  int  req_count      = 0;
  bit  in_taken       = 1'b0;
  bit  out_taken      = 1'b0;
  bit  drv_busy       = 1'b0;

  function automatic int clamp_reg(int v, int hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic int next_phase(int ph, int st);
    return (ph + 1 >= st) ? 0 : ph + 1;
  endfunction

  // Applies one request to the shadow; returns 1 when it closes a grid window.
  function automatic bit conv_predict(input in_item_t req, output out_item_t res);
    int     rows, cols, kr, kc, st, size, r, c, top, left, last_top, last_left, base;
    longint acc;
    bit     hit;
    rows = clamp_reg(reg_rows, MAX_ROWS);
    cols = clamp_reg(reg_cols, LINE_COLS);
    kr   = clamp_reg(reg_krows, KMAX);
    kc   = clamp_reg(reg_kcols, KMAX);
    st   = clamp_reg(reg_step, MAX_STEP);
    hit  = 1'b0;
    res  = '0;
    if (req.mode == MODE_WEIGHT) begin
      size = kr * kc;
      if (tap_ptr >= size) tap_ptr = '0;
      tap_mem[tap_ptr] = req.value;
      tap_ptr = (tap_ptr + 1 >= size) ? '0 : 6'(tap_ptr + 1);
      return 1'b0;
    end
    // position left over from larger sizes restarts the row / frame
    if (cur_col >= cols) begin
      cur_col = '0;
      col_ph  = '0;
    end
    if (cur_row >= rows) begin
      cur_row = '0;
      row_ph  = '0;
    end
    r = cur_row;
    c = cur_col;
    pix_mem[(r % KMAX) * LINE_COLS + c] = req.value;
    if (r + 1 >= kr && c + 1 >= kc) begin
      if (row_ph == 0 && col_ph == 0) begin
        top       = r + 1 - kr;
        left      = c + 1 - kc;
        last_top  = ((rows - kr) / st) * st;
        last_left = ((cols - kc) / st) * st;
        acc       = 0;
        for (int k = 0; k < kr; k++) begin
          base = ((top + k) % KMAX) * LINE_COLS;
          for (int l = 0; l < kc; l++)
            acc += longint'(pix_mem[base + left + l]) * longint'(tap_mem[k * kc + l]);
        end
        res.conv_value    = acc[CONV_BITS-1:0];
        res.out_row       = ROW_BITS'(top / st);
        res.out_col       = COL_BITS'(left / st);
        res.last_of_frame = (top == last_top && left == last_left);
        hit = 1'b1;
      end
      col_ph = PHASE_BITS'(next_phase(col_ph, st));
    end
    if (c + 1 >= cols) begin
      if (r + 1 >= kr) row_ph = PHASE_BITS'(next_phase(row_ph, st));
      cur_col = '0;
      col_ph  = '0;
      if (r + 1 >= rows) begin
        cur_row = '0;
        row_ph  = '0;
      end else begin
        cur_row = ROW_BITS'(r + 1);
      end
    end else begin
      cur_col = COL_BITS'(c + 1);
    end
    return hit;
  endfunction

  task automatic flag_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%t mismatch: %s", $realtime, msg);
  endtask

  // --------------------------------------------------------------------------
  // Monitor: all sampling happens at the rising edge.
  // Result compare runs before the new prediction, so an early result can
  // never be matched against a window that was only just requested.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t exp_res;
    out_item_t new_res;
    bit        cfg_taken;
    in_taken  = rst_n && in_valid && !in_stall;
    out_taken = rst_n && out_valid && !out_stall;
    cfg_taken = rst_n && cfg_valid && cfg_ready;
    if (out_taken) begin
      out_count++;
      if (conv_expect_q.size() == 0) begin
        flag_error($sformatf("unexpected result conv=%0d row=%0d col=%0d last=%0b",
                             out_data.conv_value, out_data.out_row, out_data.out_col,
                             out_data.last_of_frame));
      end else begin
        exp_res = conv_expect_q.pop_front();
        if (out_data.conv_value !== exp_res.conv_value ||
            out_data.out_row !== exp_res.out_row ||
            out_data.out_col !== exp_res.out_col ||
            out_data.last_of_frame !== exp_res.last_of_frame)
          flag_error($sformatf(
            "exp conv=%0d row=%0d col=%0d last=%0b, got conv=%0d row=%0d col=%0d last=%0b",
            exp_res.conv_value, exp_res.out_row, exp_res.out_col, exp_res.last_of_frame,
            out_data.conv_value, out_data.out_row, out_data.out_col,
            out_data.last_of_frame));
      end
    end
    if (in_taken && conv_predict(in_data, new_res)) conv_expect_q = {conv_expect_q, new_res};
    if (cfg_taken) begin
      case (cfg_index)
        CFG_IMAGE_ROWS:  reg_rows  = cfg_data[IMG_ROW_BITS-1:0];
        CFG_IMAGE_COLS:  reg_cols  = cfg_data[10:0];
        CFG_KERNEL_ROWS: reg_krows = cfg_data[3:0];
        CFG_KERNEL_COLS: reg_kcols = cfg_data[3:0];
        CFG_STEP_SIZE:   reg_step  = cfg_data[STEP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Watchdog: any handshake counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Per-request wait, with stretches where one side never idles.
  function automatic int draw_wait(inout int calm_left, inout bit calm);
    if (calm_left == 0) begin
      calm      = ($urandom_range(0, 3) == 0);
      calm_left = $urandom_range(16, 64);
    end
    calm_left--;
    return calm ? 0 : $urandom_range(0, 18);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: inputs move on the falling edge only. in_taken was latched at the
  // rising edge just before, so a held request stays put until it is taken.
  // --------------------------------------------------------------------------
  int       drv_wait      = 0;
  int       drv_calm_left = 0;
  bit       drv_calm      = 1'b0;
  in_item_t drv_item      = '0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_taken) begin
        drv_busy = 1'b0;
        drv_wait = draw_wait(drv_calm_left, drv_calm);
      end
      if (!drv_busy) begin
        if (drv_wait > 0) begin
          drv_wait--;
        end else if (req_q.size() > 0) begin
          drv_item = req_q.pop_front();
          drv_busy = 1'b1;
        end
      end
      // one assignment per edge keeps valid high across back-to-back requests
      in_valid <= drv_busy;
      in_data  <= drv_item;
    end
  end

  // Receiver: stall count drawn per result; one long hold-off fills the unit
  // once the sequence raises hold_go.
  int rx_hold      = 0;
  int rx_calm_left = 0;
  bit rx_calm      = 1'b0;
  bit hold_go      = 1'b0;
  bit hold_done    = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_taken)
        rx_hold = draw_wait(rx_calm_left, rx_calm);
      if (hold_go && !hold_done) begin
        rx_hold   = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_req(input logic mode, input logic signed [VALUE_BITS-1:0] v);
    in_item_t it;
    it.mode  = mode;
    it.value = v;
    req_q = {req_q, it};
    req_count++;
  endtask

  function automatic logic signed [VALUE_BITS-1:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return $urandom_range(0, 1) ? 16'sh0000 : 16'shFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Sender pause: queue drained, every window back, then settle time for
  // requests that produce no result.
  task automatic wait_idle();
    do @(negedge clk);
    while (req_q.size() > 0 || drv_busy || conv_expect_q.size() > 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // cfg_valid stays high across consecutive writes; cfg_release drops it.
  task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk);
    while (!cfg_ready);
  endtask

  task automatic cfg_release();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_cfg(input logic [CFG_DATA_BITS-1:0] rows, cols, kr, kc, st);
    cfg_write(CFG_IMAGE_ROWS, rows);
    cfg_write(CFG_IMAGE_COLS, cols);
    cfg_write(CFG_KERNEL_ROWS, kr);
    cfg_write(CFG_KERNEL_COLS, kc);
    cfg_write(CFG_STEP_SIZE, st);
    cfg_release();
  endtask

  // 4-bit register with random upper bits; 1 sometimes as 0, 8 as 8..15.
  function automatic logic [CFG_DATA_BITS-1:0] enc_small(int v);
    logic [CFG_DATA_BITS-1:0] n;
    n = 13'($urandom);
    if (v == 1 && n[0])      n[3:0] = 4'd0;
    else if (v == 8 && n[1]) n[3:0] = {1'b1, n[3:1]};
    else                     n[3:0] = 4'(v);
    return n;
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] enc_cols(int v);
    logic [CFG_DATA_BITS-1:0] n;
    n = 13'($urandom);
    n[10:0] = (v == 1 && n[0]) ? 11'd0 : 11'(v);
    return n;
  endfunction

  function automatic int pick_size();
    case ($urandom_range(0, 5))
      0:       return 1;
      1:       return 8;
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  // One random setting: load a whole kernel, then frames of random samples
  // with stray weight reloads; sometimes the last frame is cut short.
  task automatic run_random_phase();
    int kr, kc, st, rows, cols, flen, nfr, len;
    kr   = pick_size();
    kc   = pick_size();
    st   = pick_size();
    rows = ($urandom_range(0, 9) == 0) ? $urandom_range(1, kr) : kr + $urandom_range(0, 5);
    cols = ($urandom_range(0, 9) == 0) ? $urandom_range(1, kc) : kc + $urandom_range(0, 8);
    // A broken frame is left behind: shrink the image so the scan restarts
    // cleanly instead of picking up rows that were never filled.
    if (cur_col > 0 && cols > cur_col) cols = $urandom_range(1, cur_col);
    if (cur_row > 0 && rows > cur_row) rows = $urandom_range(1, cur_row);
    cfg_write(CFG_IMAGE_ROWS, (rows == 1 && $urandom_range(0, 1)) ? 13'd0 : 13'(rows));
    cfg_write(CFG_IMAGE_COLS, enc_cols(cols));
    cfg_write(CFG_KERNEL_ROWS, enc_small(kr));
    cfg_write(CFG_KERNEL_COLS, enc_small(kc));
    cfg_write(CFG_STEP_SIZE, enc_small(st));
    cfg_release();
    // kr*kc weights from any pointer cover every tap
    repeat (kr * kc) push_req(MODE_WEIGHT, rand_value());
    flen = rows * cols;
    nfr  = (60 + flen - 1) / flen;
    for (int f = 0; f < nfr; f++) begin
      len = flen;
      if (f == nfr - 1 && flen > 1 && $urandom_range(0, 3) == 0)
        len = $urandom_range(1, flen - 1);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 15) == 0) push_req(MODE_WEIGHT, rand_value());
        push_req(MODE_SAMPLE, rand_value());
      end
    end
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int random_base;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset setting, 1x1 everywhere: every sample is a full frame.
    push_req(MODE_WEIGHT, VAL_MAX);
    push_req(MODE_SAMPLE, VAL_MIN);
    push_req(MODE_SAMPLE, VAL_MAX);
    push_req(MODE_SAMPLE, 16'sh0000);
    push_req(MODE_SAMPLE, 16'shFFFF);
    push_req(MODE_WEIGHT, VAL_MIN);
    push_req(MODE_SAMPLE, VAL_MIN);
    push_req(MODE_SAMPLE, VAL_MAX);
    wait_idle();

    // All registers zero (upper bits set where they are ignored): read as 1.
    set_cfg(13'd0, 13'h1800, 13'h1FF0, 13'h1FF0, 13'h1FF0);
    push_req(MODE_WEIGHT, 16'sh5555);
    push_req(MODE_SAMPLE, 16'shAAAA);
    push_req(MODE_SAMPLE, 16'sh5555);
    wait_idle();

    // Oversized kernel and stride clamp to 8x8 / 8; 9x9 image, one window.
    // Most negative everywhere: the largest possible sum.
    set_cfg(13'd9, 13'd9, 13'h1FFF, 13'h1FFF, 13'h1FFF);
    repeat (64) push_req(MODE_WEIGHT, VAL_MIN);
    repeat (81) push_req(MODE_SAMPLE, VAL_MIN);
    wait_idle();

    // Kernel taller than the image: two frames wrap with no window at all.
    set_cfg(13'd2, 13'd5, 13'd3, 13'd3, 13'd1);
    repeat (9) push_req(MODE_WEIGHT, rand_value());
    repeat (20) push_req(MODE_SAMPLE, rand_value());
    wait_idle();

    // Scan position left beyond the image by a size change.
    set_cfg(13'd4, 13'd6, 13'd2, 13'd2, 13'd1);
    repeat (4) push_req(MODE_WEIGHT, rand_value());
    repeat (10) push_req(MODE_SAMPLE, rand_value());   // stops at row 1, col 4
    wait_idle();
    cfg_write(CFG_IMAGE_COLS, 13'd3);                  // col 4 now past the row end
    cfg_release();
    repeat (6) push_req(MODE_SAMPLE, rand_value());    // stops at row 3, col 0
    wait_idle();
    cfg_write(CFG_IMAGE_ROWS, 13'd2);                  // row 3 now past the frame end
    cfg_release();
    repeat (6) push_req(MODE_SAMPLE, rand_value());
    wait_idle();

    // Stride cut from 4 to 2 while both phases sit at 3.
    set_cfg(13'd8, 13'd4, 13'd1, 13'd1, 13'd4);
    push_req(MODE_WEIGHT, rand_value());
    repeat (15) push_req(MODE_SAMPLE, rand_value());
    wait_idle();
    cfg_write(CFG_STEP_SIZE, 13'd2);
    cfg_release();
    repeat (17) push_req(MODE_SAMPLE, rand_value());
    wait_idle();

    // Column count clamps to 1024: a partial first row, left unfinished.
    set_cfg(13'd1, 13'h1FFF, 13'd1, 13'd1, 13'd1);
    push_req(MODE_WEIGHT, rand_value());
    repeat (COL_CLAMP_LEN) push_req(MODE_SAMPLE, rand_value());
    wait_idle();

    // Row count clamps to 4096, one column: the column restarts, then a run
    // of rows. The long receiver hold-off lands in here while the driver
    // keeps offering samples.
    set_cfg(13'h1FFF, 13'd1, 13'd1, 13'd1, 13'd1);
    hold_go = 1'b1;
    push_req(MODE_WEIGHT, rand_value());
    repeat (ROW_CLAMP_LEN) push_req(MODE_SAMPLE, rand_value());
    wait_idle();

    random_base = req_count;
    while (req_count - random_base < RANDOM_REQS) run_random_phase();

    // wait_idle already drained everything and let the unit settle
    if (conv_expect_q.size() > 0)
      flag_error($sformatf("%0d expected results never arrived", conv_expect_q.size()));
    if (mismatch_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
